// ===== design/gcol_pkg.sv =====
// ----------------------------------------------------------------------------
// gcol_pkg
// Shared types and fixed field widths for the greedy graph colourer.
// ----------------------------------------------------------------------------
package gcol_pkg;

  // fixed widths of the request and result fields
  localparam int VERTEX_W = 12;
  localparam int COLOR_W  = 8;
  localparam int USED_W   = 9;
  // wide enough to compare a vertex against the largest vertex limit
  localparam int MAXV_W   = 21;

  // request action codes
  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_NEIGHBOR = 1'b1;

  // colour store sequencer
  typedef enum logic {
    ST_RUN,
    ST_CLEAR
  } phase_t;

  // gather stage control, one word per request in flight
  typedef struct packed {
    logic valid;   // request present in the gather stage
    logic start;   // start of a new colouring
    logic last;    // final neighbour request of a vertex
    logic mark;    // neighbour is coloured: mark its colour
  } bctl_t;

endpackage

// ===== design/gcol_store.sv =====
// ----------------------------------------------------------------------------
// gcol_store
// Per-vertex colour store: one read port, one write port, a clearing sweep
// after reset and after each start request.
// ----------------------------------------------------------------------------
module gcol_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int CW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_valid,
  output logic [CW-1:0] rd_color,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [CW-1:0] wr_color,
  input  logic          start_clear,
  output logic          busy
);

  // entry: valid bit above the colour
  logic [CW:0]     mem [DEPTH];
  logic [CW:0]     rdata;

  gcol_pkg::phase_t state, state_next;
  logic [AW-1:0]   cnt, cnt_next;
  logic            we;
  logic [AW-1:0]   wa;
  logic [CW:0]     wd;

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    case (state)
      gcol_pkg::ST_RUN: begin
        if (start_clear) begin
          state_next = gcol_pkg::ST_CLEAR;
        end
      end
      gcol_pkg::ST_CLEAR: begin
        cnt_next = cnt + 1'b1;
        if (cnt == AW'(DEPTH - 1)) begin
          state_next = gcol_pkg::ST_RUN;
          cnt_next   = '0;
        end
      end
      default: begin
        state_next = gcol_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy = 1'b0;
    we   = wr_en;
    wa   = wr_addr;
    wd   = {1'b1, wr_color};
    case (state)
      gcol_pkg::ST_RUN: begin
        busy = 1'b0;
      end
      gcol_pkg::ST_CLEAR: begin
        busy = 1'b1;
        we   = 1'b1;
        wa   = cnt;
        wd   = '0;
      end
      default: begin
        busy = 1'b1;
        we   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcol_pkg::ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign rd_valid = rdata[CW];
  assign rd_color = rdata[CW-1:0];

endmodule

// ===== design/gcol_gather.sv =====
// ----------------------------------------------------------------------------
// gcol_gather
// Presence bitmap of neighbour colours and the registered per-group summary
// (group full, first free position) taken on the last request of a vertex.
// ----------------------------------------------------------------------------
module gcol_gather #(
  parameter int COLOR_LIMIT = 256,
  parameter int CW          = 8,
  parameter int GW          = 4,
  parameter int G           = 16,
  parameter int NG          = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gcol_pkg::bctl_t        bctl,
  input  logic [CW-1:0]          mark_color,
  output logic [NG-1:0]          grp_full,
  output logic [NG-1:0][GW-1:0]  grp_idx
);

  logic [COLOR_LIMIT-1:0]  bitmap;
  logic [COLOR_LIMIT-1:0]  merged;
  logic [NG*G-1:0]         padded;
  logic [NG-1:0]           full_c;
  logic [NG-1:0][GW-1:0]   idx_c;

  always_comb begin
    merged = bitmap;
    if (bctl.mark) begin
      merged = bitmap | ({{(COLOR_LIMIT-1){1'b0}}, 1'b1} << mark_color);
    end
    // positions beyond the limit count as taken
    padded = '1;
    padded[COLOR_LIMIT-1:0] = merged;
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      full_c[g] = &padded[g*G +: G];
      idx_c[g]  = '0;
      for (int i = G - 1; i >= 0; i--) begin
        if (!padded[g*G + i]) begin
          idx_c[g] = GW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap <= '0;
    end else if (bctl.valid && (bctl.start || bctl.last)) begin
      bitmap <= '0;
    end else if (bctl.valid) begin
      bitmap <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (bctl.valid && !bctl.start && bctl.last) begin
      grp_full <= full_c;
      grp_idx  <= idx_c;
    end
  end

endmodule

// ===== design/gcol_pick.sv =====
// ----------------------------------------------------------------------------
// gcol_pick
// Pick the smallest free colour from the group summary, write it back to the
// store, track the highest colour and hold the result register.
// ----------------------------------------------------------------------------
module gcol_pick #(
  parameter int COLOR_LIMIT = 256,
  parameter int AW          = 12,
  parameter int CW          = 8,
  parameter int GW          = 4,
  parameter int NG          = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gcol_pkg::bctl_t                   bctl,
  input  logic [gcol_pkg::VERTEX_W-1:0]     load_vertex,
  input  logic                              load_vin,
  input  logic [NG-1:0]                     grp_full,
  input  logic [NG-1:0][GW-1:0]             grp_idx,
  output logic                              s1_busy,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic [CW-1:0]                     wr_color,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [gcol_pkg::VERTEX_W-1:0]     colored_vertex,
  output logic [gcol_pkg::COLOR_W-1:0]      color,
  output logic [gcol_pkg::USED_W-1:0]       colors_used,
  output logic                              overflow
);

  logic                          s1_valid;
  logic [gcol_pkg::VERTEX_W-1:0] s1_vertex;
  logic                          s1_vin;
  logic [CW-1:0]                 highest;
  logic [CW-1:0]                 highest_next;
  logic                          found;
  logic [CW+GW-1:0]              cwide;
  logic [CW-1:0]                 pick;
  logic [CW:0]                   used;
  logic                          advance;

  always_comb begin
    found = 1'b0;
    cwide = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (!grp_full[g]) begin
        found = 1'b1;
        cwide = ((CW+GW)'(g) << GW) | (CW+GW)'(grp_idx[g]);
      end
    end
    pick         = found ? cwide[CW-1:0] : CW'(COLOR_LIMIT - 1);
    highest_next = (pick > highest) ? pick : highest;
    used         = {1'b0, highest_next} + (CW+1)'(1);
  end

  assign advance  = s1_valid && (!res_valid || res_ready);
  assign s1_busy  = s1_valid;
  assign wr_en    = advance && s1_vin;
  assign wr_addr  = s1_vertex[AW-1:0];
  assign wr_color = pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      highest   <= '0;
    end else begin
      if (bctl.valid && !bctl.start && bctl.last) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (bctl.valid && bctl.start) begin
        highest <= '0;
      end else if (advance) begin
        highest <= highest_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bctl.valid && !bctl.start && bctl.last) begin
      s1_vertex <= load_vertex;
      s1_vin    <= load_vin;
    end
    if (advance) begin
      colored_vertex <= s1_vertex;
      color          <= gcol_pkg::COLOR_W'(pick);
      colors_used    <= gcol_pkg::USED_W'(used);
      overflow       <= !found;
    end
  end

endmodule

// ===== design/greedy_graph_colorer.sv =====
// ----------------------------------------------------------------------------
// greedy_graph_colorer
// Greedy graph colouring over a stream of neighbour requests: gather the
// colours of coloured neighbours, give the vertex the smallest free colour.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------------------------
//  request   req_valid/req_ready   action, vertex, neighbor, has_neighbor, last
//  result    res_valid/res_ready   colored_vertex, color, colors_used, overflow
//
//  A neighbour request without last does not hold back the next request: the
//  colour store read is issued at acceptance and the bitmap is updated in the
//  following cycle. A last request passes through three steps (store read,
//  bitmap merge with group summary, colour pick with store write-back); the
//  next request waits for the write-back, and longer if the result register
//  is still full. Reset and every start request run a clearing sweep over all
//  min(MAX_VERTICES, 4096) entries of the colour store, one entry a cycle,
//  with req_ready low. The result register holds while res_ready is low;
//  neighbour requests are still taken meanwhile.
// ----------------------------------------------------------------------------
module greedy_graph_colorer #(
  parameter int MAX_VERTICES = 4096,
  parameter int COLOR_LIMIT  = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              action,
  input  logic [gcol_pkg::VERTEX_W-1:0]     vertex,
  input  logic [gcol_pkg::VERTEX_W-1:0]     neighbor,
  input  logic                              has_neighbor,
  input  logic                              last,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [gcol_pkg::VERTEX_W-1:0]     colored_vertex,
  output logic [gcol_pkg::COLOR_W-1:0]      color,
  output logic [gcol_pkg::USED_W-1:0]       colors_used,
  output logic                              overflow
);

  // vertices beyond the field range can never be stored
  localparam int VSPAN = 1 << gcol_pkg::VERTEX_W;
  localparam int DEPTH = (MAX_VERTICES < VSPAN) ? MAX_VERTICES : VSPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLOR_LIMIT);
  // two-level free-colour search: groups of G positions
  localparam int GW    = (CW + 1) / 2;
  localparam int G     = 1 << GW;
  localparam int NG    = (COLOR_LIMIT + G - 1) / G;
  localparam int MW    = gcol_pkg::MAXV_W;

  logic                          accept;
  logic                          busy;
  logic                          s1_busy;
  logic                          rd_valid;
  logic [CW-1:0]                 rd_color;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [CW-1:0]                 wr_color;
  logic [NG-1:0]                 grp_full;
  logic [NG-1:0][GW-1:0]         grp_idx;
  gcol_pkg::bctl_t               bctl;

  // gather stage registers
  logic                          b_valid;
  logic                          b_start;
  logic                          b_last;
  logic                          b_use;
  logic                          b_vin;
  logic [gcol_pkg::VERTEX_W-1:0] b_vertex;

  // Hold requests during the sweep, while a start is on its way to the
  // sweep, while a last request is in the gather stage, and while a colour is
  // being picked and written back: the next neighbour read must see that colour.
  assign req_ready = !busy && !(b_valid && (b_start || b_last)) && !s1_busy;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_start  <= (action == gcol_pkg::ACT_START);
      b_last   <= (action == gcol_pkg::ACT_NEIGHBOR) && last;
      // drop neighbours that are absent or beyond the vertex limit
      b_use    <= (action == gcol_pkg::ACT_NEIGHBOR) && has_neighbor &&
                  (MW'(neighbor) < MW'(MAX_VERTICES));
      b_vin    <= MW'(vertex) < MW'(MAX_VERTICES);
      b_vertex <= vertex;
    end
  end

  always_comb begin
    bctl.valid = b_valid;
    bctl.start = b_start;
    bctl.last  = b_last;
    bctl.mark  = b_valid && b_use && rd_valid;
  end

  gcol_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (accept),
    .rd_addr     (neighbor[AW-1:0]),
    .rd_valid    (rd_valid),
    .rd_color    (rd_color),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_color    (wr_color),
    .start_clear (b_valid && b_start),
    .busy        (busy)
  );

  gcol_gather #(
    .COLOR_LIMIT (COLOR_LIMIT),
    .CW          (CW),
    .GW          (GW),
    .G           (G),
    .NG          (NG)
  ) u_gather (
    .clk        (clk),
    .rst        (rst),
    .bctl       (bctl),
    .mark_color (rd_color),
    .grp_full   (grp_full),
    .grp_idx    (grp_idx)
  );

  gcol_pick #(
    .COLOR_LIMIT (COLOR_LIMIT),
    .AW          (AW),
    .CW          (CW),
    .GW          (GW),
    .NG          (NG)
  ) u_pick (
    .clk            (clk),
    .rst            (rst),
    .bctl           (bctl),
    .load_vertex    (b_vertex),
    .load_vin       (b_vin),
    .grp_full       (grp_full),
    .grp_idx        (grp_idx),
    .s1_busy        (s1_busy),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_color       (wr_color),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .colored_vertex (colored_vertex),
    .color          (color),
    .colors_used    (colors_used),
    .overflow       (overflow)
  );

endmodule

// ===== design/gcol_checker.sv =====
// ----------------------------------------------------------------------------
// gcol_checker
// Port-level checks of the greedy graph colourer, bound to the top level.
// ----------------------------------------------------------------------------
module gcol_checker #(
  parameter int COLOR_LIMIT = 256
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          action,
  input logic                          last,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [gcol_pkg::VERTEX_W-1:0] colored_vertex,
  input logic [gcol_pkg::COLOR_W-1:0]  color,
  input logic [gcol_pkg::USED_W-1:0]   colors_used,
  input logic                          overflow
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(colored_vertex) &&
    $stable(color) && $stable(colors_used) && $stable(overflow))
    else $error("result changed while stalled");

  // write-back interlock after a last request
  a_last_lock: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (action == gcol_pkg::ACT_NEIGHBOR) && last
    |=> !req_ready)
    else $error("request taken before write-back");

  // a taken start request holds back the next request
  a_start_lock: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (action == gcol_pkg::ACT_START) |=> !req_ready)
    else $error("request taken before clearing sweep");

  // a new result is produced only while requests are held
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(req_ready))
    else $error("result appeared without a colour pick");

  // a saturated colour is the top colour
  a_ovf_color: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> color == gcol_pkg::COLOR_W'(COLOR_LIMIT - 1))
    else $error("overflow with wrong colour");

endmodule

bind greedy_graph_colorer gcol_checker #(
  .COLOR_LIMIT (COLOR_LIMIT)
) u_gcol_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_ready      (req_ready),
  .action         (action),
  .last           (last),
  .res_valid      (res_valid),
  .res_ready      (res_ready),
  .colored_vertex (colored_vertex),
  .color          (color),
  .colors_used    (colors_used),
  .overflow       (overflow)
);

// ===== dv/greedy_graph_colorer_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_graph_colorer_tb
// Self-checking bench for the greedy graph colourer. A table of directed
// requests runs first. A deep pass then builds a tower of vertices whose
// colours climb from 0, and a vertex next to the whole tower takes the next
// colour. Random groups, noise and starts with gaps and result stalls follow.
// Each result is checked in order against a typed row or a behavioural model.
// ----------------------------------------------------------------------------
module greedy_graph_colorer_tb;

  localparam int VERTEX_W       = gcol_pkg::VERTEX_W;
  localparam int COLOR_W        = gcol_pkg::COLOR_W;
  localparam int USED_W         = gcol_pkg::USED_W;

  localparam int NUM_VERTICES   = 4096;
  localparam int NUM_COLORS     = 256;
  localparam int TOWER_COLORS   = 16;
  localparam int RANDOM_TARGET  = 600;
  localparam int MAX_STARTS     = 16;
  localparam int MAX_GAP        = 17;
  localparam int DRAIN_CYCLES   = 64;
  localparam int NEAR_POOL      = 31;

  // one result of the colourer, as the predictor expects it
  typedef struct packed {
    logic [VERTEX_W-1:0] vtx;
    logic [COLOR_W-1:0]  col;
    logic [USED_W-1:0]   used;
    logic                ovf;
  } coloring_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_QUIET,   // no result expected
    ROW_TYPED,   // result typed into the table
    ROW_MODEL    // result taken from the predictor
  } row_kind_t;

  typedef struct packed {
    logic                act;
    logic [VERTEX_W-1:0] vtx;
    logic [VERTEX_W-1:0] nbr;
    logic                hn;
    logic                lst;
    row_kind_t           kind;
    coloring_t           exp;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_ready;
  logic                action;
  logic [VERTEX_W-1:0] vertex;
  logic [VERTEX_W-1:0] neighbor;
  logic                has_neighbor;
  logic                last;
  logic                res_valid;
  logic                res_ready;
  logic [VERTEX_W-1:0] colored_vertex;
  logic [COLOR_W-1:0]  color;
  logic [USED_W-1:0]   colors_used;
  logic                overflow;

  // predictor state: the colour of each vertex, the colours seen in the
  // current neighbour group, and the highest colour given so far
  bit                  is_colored [NUM_VERTICES];
  logic [COLOR_W-1:0]  shade_of   [NUM_VERTICES];
  logic [NUM_COLORS-1:0] seen_shades;
  logic [COLOR_W-1:0]  top_shade;

  coloring_t           pending_colorings [$];
  dir_row_t            dir_rows [$];
  int                  errors;
  int                  random_items;
  int                  starts_sent;
  bit                  idle_off;

  greedy_graph_colorer dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .action         (action),
    .vertex         (vertex),
    .neighbor       (neighbor),
    .has_neighbor   (has_neighbor),
    .last           (last),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .colored_vertex (colored_vertex),
    .color          (color),
    .colors_used    (colors_used),
    .overflow       (overflow)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop: far beyond the slowest legal run, clearing sweeps included.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // Advance the predictor by one accepted request. Return 1 with the expected
  // result when the request closes a vertex.
  task automatic predict_coloring(input logic a, input logic [VERTEX_W-1:0] v,
                                  input logic [VERTEX_W-1:0] n, input logic h,
                                  input logic l, output bit got,
                                  output coloring_t res);
    int c;
    bit ovf;
    got = 1'b0;
    res = '0;
    if (a == gcol_pkg::ACT_START) begin
      // drop every colour, the gathered bitmap and the count
      for (int i = 0; i < NUM_VERTICES; i++) is_colored[i] = 1'b0;
      seen_shades = '0;
      top_shade = '0;
    end else begin
      // uncoloured neighbours leave the bitmap alone
      if (h && is_colored[n]) seen_shades[shade_of[n]] = 1'b1;
      if (l) begin
        c = NUM_COLORS;
        for (int i = NUM_COLORS - 1; i >= 0; i--) if (!seen_shades[i]) c = i;
        ovf = (c == NUM_COLORS);
        // saturate at the top colour when every colour is taken
        if (ovf) c = NUM_COLORS - 1;
        seen_shades = '0;
        is_colored[v] = 1'b1;
        shade_of[v] = c[COLOR_W-1:0];
        if (c[COLOR_W-1:0] > top_shade) top_shade = c[COLOR_W-1:0];
        res.vtx  = v;
        res.col  = c[COLOR_W-1:0];
        res.used = {1'b0, top_shade} + 9'd1;
        res.ovf  = ovf;
        got = 1'b1;
      end
    end
  endtask

  // Hold the request for a random gap, present it, wait for acceptance and
  // advance the predictor. Entered and left at a falling edge.
  task automatic send_request(input logic a, input logic [VERTEX_W-1:0] v,
                              input logic [VERTEX_W-1:0] n, input logic h,
                              input logic l, output bit got,
                              output coloring_t res);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid    <= 1'b1;
    action       <= a;
    vertex       <= v;
    neighbor     <= n;
    has_neighbor <= h;
    last         <= l;
    do @(posedge clk); while (!req_ready);
    predict_coloring(a, v, n, h, l, got, res);
    @(negedge clk);
  endtask

  // Send a request and queue whatever the predictor expects from it.
  task automatic send_checked(input logic a, input logic [VERTEX_W-1:0] v,
                              input logic [VERTEX_W-1:0] n, input logic h,
                              input logic l);
    bit got;
    coloring_t res;
    send_request(a, v, n, h, l, got, res);
    if (got) pending_colorings.push_back(res);
  endtask

  // Pause the sender until every expected result has come back.
  task automatic wait_drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending_colorings.size() != 0) @(negedge clk);
  endtask

  function automatic dir_row_t mk_row(logic a, logic [VERTEX_W-1:0] v,
                                      logic [VERTEX_W-1:0] n, logic h, logic l,
                                      row_kind_t k, logic [COLOR_W-1:0] col,
                                      logic [USED_W-1:0] used, logic ovf);
    dir_row_t r;
    r.act  = a;
    r.vtx  = v;
    r.nbr  = n;
    r.hn   = h;
    r.lst  = l;
    r.kind = k;
    r.exp  = '{vtx: v, col: col, used: used, ovf: ovf};
    return r;
  endfunction

  // Mostly a small pool of vertices so that colours collide; now and then
  // anywhere in the full vertex range.
  function automatic logic [VERTEX_W-1:0] pick_vertex();
    logic [31:0] t;
    t = $urandom;
    if ($urandom_range(0, 4) == 0) return t[VERTEX_W-1:0];
    return VERTEX_W'($urandom_range(0, NEAR_POOL));
  endfunction

  // One well-formed vertex: an isolated request, or a run of neighbour
  // requests closed by last. Mix in self loops, masked neighbours and a
  // vertex field that moves mid-group.
  task automatic random_group();
    int n;
    logic [VERTEX_W-1:0] v;
    logic [VERTEX_W-1:0] nb;
    logic [31:0] t;
    logic h;
    v = pick_vertex();
    n = $urandom_range(0, 6);
    t = $urandom;
    if (n == 0) begin
      send_checked(gcol_pkg::ACT_NEIGHBOR, v, t[VERTEX_W-1:0], 1'b0, 1'b1);
      random_items++;
    end else begin
      for (int i = 0; i < n; i++) begin
        nb = ($urandom_range(0, 19) == 0) ? v : pick_vertex();
        h = ($urandom_range(0, 9) != 0);
        send_checked(gcol_pkg::ACT_NEIGHBOR, v, nb, h, i == n - 1);
        random_items++;
        if ($urandom_range(0, 24) == 0) v = pick_vertex();
      end
    end
  endtask

  // Noise: any field pattern on a neighbour request, last at random.
  task automatic random_noise();
    logic [31:0] t;
    t = $urandom;
    send_checked(gcol_pkg::ACT_NEIGHBOR, t[VERTEX_W-1:0],
                 t[2*VERTEX_W-1:VERTEX_W], t[24], t[25]);
    random_items++;
  endtask

  // Result side: stall for a random gap before each result, then take it.
  initial begin
    res_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int stall;
      stall = idle_off ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_colorings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got vertex %0d color %0d",
                 $time, colored_vertex, color);
      end else begin
        coloring_t e;
        e = pending_colorings.pop_front();
        if (colored_vertex !== e.vtx) begin
          errors++;
          $display("%0t: colored_vertex expected %0d got %0d", $time, e.vtx,
                   colored_vertex);
        end
        if (color !== e.col) begin
          errors++;
          $display("%0t: color expected %0d got %0d", $time, e.col, color);
        end
        if (colors_used !== e.used) begin
          errors++;
          $display("%0t: colors_used expected %0d got %0d", $time, e.used,
                   colors_used);
        end
        if (overflow !== e.ovf) begin
          errors++;
          $display("%0t: overflow expected %0d got %0d", $time, e.ovf, overflow);
        end
      end
    end
  end

  initial begin
    bit got;
    coloring_t res;
    dir_row_t r;
    int pick;

    errors       = 0;
    random_items = 0;
    starts_sent  = 0;
    idle_off     = 1'b0;
    seen_shades  = '0;
    top_shade    = '0;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      is_colored[i] = 1'b0;
      shade_of[i]   = '0;
    end

    rst          = 1'b1;
    req_valid    = 1'b0;
    action       = gcol_pkg::ACT_START;
    vertex       = '0;
    neighbor     = '0;
    has_neighbor = 1'b0;
    last         = 1'b0;

    // Directed table. Typed results are those readable at a glance.
    // isolated vertex straight after reset
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd0, 12'hFFF, 1'b0, 1'b1,
                              ROW_TYPED, 8'd0, 9'd1, 1'b0));
    // top vertex next to the only coloured one
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'hFFF, 12'd0, 1'b1, 1'b1,
                              ROW_TYPED, 8'd1, 9'd2, 1'b0));
    // two coloured neighbours in one group
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd1, 12'hFFF, 1'b1, 1'b0,
                              ROW_QUIET, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd1, 12'd0, 1'b1, 1'b1,
                              ROW_MODEL, '0, '0, 1'b0));
    // neighbour field masked by has_neighbor low
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd2, 12'hFFF, 1'b0, 1'b1,
                              ROW_MODEL, '0, '0, 1'b0));
    // self loop: vertex recoloured over its own colour, count never drops
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd0, 12'd0, 1'b1, 1'b1,
                              ROW_MODEL, '0, '0, 1'b0));
    // vertex field moves mid-group: only the one on last counts
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd5, 12'd0, 1'b1, 1'b0,
                              ROW_QUIET, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd6, 12'd1, 1'b1, 1'b1,
                              ROW_MODEL, '0, '0, 1'b0));
    // uncoloured neighbour is ignored
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd7, 12'd3000, 1'b1, 1'b1,
                              ROW_MODEL, '0, '0, 1'b0));
    // masked neighbour mid-group, then a coloured one
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd8, 12'd1, 1'b0, 1'b0,
                              ROW_QUIET, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd8, 12'd6, 1'b1, 1'b1,
                              ROW_MODEL, '0, '0, 1'b0));
    // start with every other field high: nothing comes out
    dir_rows.push_back(mk_row(gcol_pkg::ACT_START, 12'hFFF, 12'hFFF, 1'b1, 1'b1,
                              ROW_QUIET, '0, '0, 1'b0));
    // former colours are gone after the start
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'hFFF, 12'd0, 1'b1, 1'b1,
                              ROW_TYPED, 8'd0, 9'd1, 1'b0));
    dir_rows.push_back(mk_row(gcol_pkg::ACT_START, 12'd0, 12'd0, 1'b0, 1'b0,
                              ROW_QUIET, '0, '0, 1'b0));
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'd0, 12'hFFF, 1'b1, 1'b1,
                              ROW_TYPED, 8'd0, 9'd1, 1'b0));
    dir_rows.push_back(mk_row(gcol_pkg::ACT_NEIGHBOR, 12'hABC, 12'd0, 1'b1, 1'b1,
                              ROW_TYPED, 8'd1, 9'd2, 1'b0));

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_request(r.act, r.vtx, r.nbr, r.hn, r.lst, got, res);
      case (r.kind)
        ROW_TYPED: pending_colorings.push_back(r.exp);
        ROW_MODEL: if (got) pending_colorings.push_back(res);
        default: ;
      endcase
    end
    wait_drain();

    // Deep pass without idling: vertex k takes neighbours 0..k-1, so it
    // gets colour k. Then a vertex next to the whole tower takes the next one.
    idle_off = 1'b1;
    send_checked(gcol_pkg::ACT_START, '0, '0, 1'b0, 1'b0);
    send_checked(gcol_pkg::ACT_NEIGHBOR, 12'd0, 12'd0, 1'b0, 1'b1);
    for (int k = 1; k < TOWER_COLORS; k++) begin
      for (int j = 0; j < k; j++)
        send_checked(gcol_pkg::ACT_NEIGHBOR, VERTEX_W'(k), VERTEX_W'(j), 1'b1,
                     j == k - 1);
    end
    for (int j = 0; j < TOWER_COLORS; j++)
      send_checked(gcol_pkg::ACT_NEIGHBOR, 12'd1000, VERTEX_W'(j), 1'b1,
                   j == TOWER_COLORS - 1);
    idle_off = 1'b0;
    wait_drain();

    // Random part: mostly well-formed groups, some noise and starts, the
    // odd burst without idling and the odd pause for the results.
    while (random_items < RANDOM_TARGET) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) idle_off = ~idle_off;
      if (pick < 2 && starts_sent < MAX_STARTS) begin
        send_checked(gcol_pkg::ACT_START, pick_vertex(), pick_vertex(), pick[0],
                     1'($urandom_range(0, 1)));
        starts_sent++;
        random_items++;
      end else if (pick < 4) begin
        wait_drain();
      end else if (pick < 12) begin
        random_noise();
      end else begin
        random_group();
      end
    end
    idle_off = 1'b0;

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gcol_pkg.sv
design/gcol_store.sv
design/gcol_gather.sv
design/gcol_pick.sv
design/greedy_graph_colorer.sv
design/gcol_checker.sv
dv/greedy_graph_colorer_tb.sv
